// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file afd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define AFD_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that is also checked during reset
`define AFD_ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/afd_pkg.sv =====
package afd_pkg;

   localparam logic [3:0] FRAME_BYTES   = 4'd9;
   localparam logic [3:0] LAST_DATA_POS = 4'd8;
   localparam logic [3:0] FIRST_DATA_POS = 4'd1;
   localparam logic [3:0] HEADER_POS    = 4'd0;

   localparam int unsigned PRED_SHIFT = 11;

   localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAT_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [13:0] c1;
      logic signed [13:0] c2;
   } coeff_pair_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               last_of_byte;
      logic               frame_end;
   } rsp_word_type;

   // fixed predictor coefficient pairs, selected by the header low nibble
   function automatic coeff_pair_type coeff_lookup(input logic [3:0] sel);
      coeff_pair_type pair;
      case (sel)
         4'd0:    pair = '{c1:  14'sd0,    c2:  14'sd0};
         4'd1:    pair = '{c1:  14'sd2048, c2:  14'sd0};
         4'd2:    pair = '{c1:  14'sd0,    c2:  14'sd2048};
         4'd3:    pair = '{c1:  14'sd1024, c2:  14'sd1024};
         4'd4:    pair = '{c1:  14'sd4096, c2: -14'sd2048};
         4'd5:    pair = '{c1:  14'sd3584, c2: -14'sd1536};
         4'd6:    pair = '{c1:  14'sd3072, c2: -14'sd1024};
         4'd7:    pair = '{c1:  14'sd4608, c2: -14'sd2560};
         4'd8:    pair = '{c1:  14'sd4200, c2: -14'sd2248};
         4'd9:    pair = '{c1:  14'sd4800, c2: -14'sd2300};
         4'd10:   pair = '{c1:  14'sd5120, c2: -14'sd3072};
         4'd11:   pair = '{c1:  14'sd2048, c2: -14'sd2048};
         4'd12:   pair = '{c1:  14'sd1024, c2: -14'sd1024};
         4'd13:   pair = '{c1: -14'sd1024, c2:  14'sd1024};
         4'd14:   pair = '{c1: -14'sd1024, c2:  14'sd0};
         4'd15:   pair = '{c1: -14'sd2048, c2:  14'sd0};
         default: pair = '{c1:  14'sd0,    c2:  14'sd0};
      endcase
      return pair;
   endfunction

endpackage

// ===== rtl/afd_predictor.sv =====
module afd_predictor
   import afd_pkg::*;
(
   input  logic signed [15:0] hist_one,
   input  logic signed [15:0] hist_two,
   input  logic        [3:0]  coeff_sel,
   input  logic        [3:0]  scale_shift,
   input  logic        [3:0]  nibble,
   output logic signed [15:0] sample
);

   coeff_pair_type     pair;
   logic signed [29:0] prod_one;
   logic signed [29:0] prod_two;
   logic        [30:0] prod_sum;
   logic        [19:0] pred;
   logic        [19:0] delta_ext;
   logic        [19:0] scaled;
   logic        [20:0] raw;
   logic               in_range;

   assign pair     = coeff_lookup(coeff_sel);
   assign prod_one = hist_one * pair.c1;
   assign prod_two = hist_two * pair.c2;
   assign prod_sum = {prod_one[29], prod_one} + {prod_two[29], prod_two};

   // arithmetic shift right rounds towards minus infinity
   assign pred = prod_sum[30:PRED_SHIFT];

   assign delta_ext = {{16{nibble[3]}}, nibble};
   assign scaled    = delta_ext << scale_shift;

   assign raw      = {pred[19], pred} + {scaled[19], scaled};
   assign in_range = (raw[20:15] == {6{raw[15]}});

   always_comb begin
      if (in_range) begin
         sample = raw[15:0];
      end else if (raw[20]) begin
         sample = SAT_MIN;
      end else begin
         sample = SAT_MAX;
      end
   end

endmodule

// ===== rtl/afd_out_reg.sv =====
module afd_out_reg
   import afd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_word_type       word_in,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_last_of_byte,
   output logic               rsp_frame_end
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // a waiting word can be replaced in the cycle it is taken
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = push || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && free) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pcm_sample   = word_ff.pcm_sample;
   assign rsp_last_of_byte = word_ff.last_of_byte;
   assign rsp_frame_end    = word_ff.frame_end;

endmodule

// ===== rtl/adpcm4_frame_decoder_core.sv =====
// 4-bit ADPCM decoder for 9-byte frames. A header byte is absorbed and
// yields no word; a data byte stays in the decode register for both of its
// samples, high nibble first, since each prediction needs the sample just
// made (two coefficient multiplies, add, shift and clip, all combinational).
// A byte can be taken while the previous result still waits in the output
// register; sustained rate is one sample per cycle when rsp_ready stays
// high, header bytes apart. Samples appear in the cycle after their decode.
module adpcm4_frame_decoder_core
   import afd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [7:0]  req_stream_byte,
   input  logic               req_wave_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_last_of_byte,
   output logic               rsp_frame_end
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic        [7:0]  in_byte_ff;
   logic               in_start_ff;
   logic               phase_ff;
   logic               phase_in;
   logic        [3:0]  pos_ff;
   logic        [3:0]  pos_in;
   logic        [3:0]  shift_ff;
   logic        [3:0]  shift_in;
   logic        [3:0]  coeff_ff;
   logic        [3:0]  coeff_in;
   logic signed [15:0] hist_one_ff;
   logic signed [15:0] hist_one_in;
   logic signed [15:0] hist_two_ff;
   logic signed [15:0] hist_two_in;

   logic               is_header;
   logic               out_free;
   logic               push;
   logic               consume;
   logic               accept;
   logic        [3:0]  nibble;
   logic signed [15:0] sample;
   rsp_word_type       word;

   // wave start forces the byte to be taken as a header
   assign is_header = in_start_ff || (pos_ff == HEADER_POS) || (pos_ff >= FRAME_BYTES);
   assign push      = in_valid_ff && !is_header && out_free;
   assign consume   = in_valid_ff && (is_header || (out_free && phase_ff));
   assign req_ready = !in_valid_ff || consume;
   assign accept    = req_valid && req_ready;

   assign nibble = phase_ff ? in_byte_ff[3:0] : in_byte_ff[7:4];

   afd_predictor u_pred (
      .hist_one    (hist_one_ff),
      .hist_two    (hist_two_ff),
      .coeff_sel   (coeff_ff),
      .scale_shift (shift_ff),
      .nibble      (nibble),
      .sample      (sample)
   );

   always_comb begin
      word.pcm_sample   = sample;
      word.last_of_byte = phase_ff;
      word.frame_end    = phase_ff && (pos_ff == LAST_DATA_POS);
   end

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !consume);
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      coeff_in    = coeff_ff;
      hist_one_in = hist_one_ff;
      hist_two_in = hist_two_ff;
      if (in_valid_ff && is_header) begin
         shift_in = in_byte_ff[7:4];
         coeff_in = in_byte_ff[3:0];
         pos_in   = FIRST_DATA_POS;
         phase_in = 1'b0;
         if (in_start_ff) begin
            hist_one_in = '0;
            hist_two_in = '0;
         end
      end else if (push) begin
         hist_two_in = hist_one_ff;
         hist_one_in = sample;
         phase_in    = !phase_ff;
         if (phase_ff) begin
            pos_in = (pos_ff == LAST_DATA_POS) ? HEADER_POS : 4'(pos_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
         pos_ff      <= HEADER_POS;
         shift_ff    <= '0;
         coeff_ff    <= '0;
         hist_one_ff <= '0;
         hist_two_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         shift_ff    <= shift_in;
         coeff_ff    <= coeff_in;
         hist_one_ff <= hist_one_in;
         hist_two_ff <= hist_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_stream_byte;
         in_start_ff <= req_wave_start;
      end
   end

   afd_out_reg u_out (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .word_in          (word),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pcm_sample   (rsp_pcm_sample),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

// ===== rtl/afd_checker.sv =====
`include "assert_macros.svh"

module afd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_pcm_sample,
   input logic               rsp_last_of_byte,
   input logic               rsp_frame_end
);

   // frame end only on the low nibble of a byte
   `AFD_ASSERT_CLK(a_frame_end_low, clock, reset, (rsp_valid && rsp_frame_end) |-> rsp_last_of_byte)

   // the low-nibble word follows right after the high-nibble word is taken
   `AFD_ASSERT_CLK(a_pair_follows, clock, reset, (rsp_valid && rsp_ready && !rsp_last_of_byte) |=> (rsp_valid && rsp_last_of_byte))

   // a stalled word holds
   `AFD_ASSERT_CLK(a_stall_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pcm_sample) && $stable(rsp_last_of_byte)))

   `AFD_ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind adpcm4_frame_decoder_core afd_checker u_afd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pcm_sample   (rsp_pcm_sample),
   .rsp_last_of_byte (rsp_last_of_byte),
   .rsp_frame_end    (rsp_frame_end)
);
